### hw/rtl/ctip_pkg.sv
// Package for the checked integer text parser.
// Types, codes and character helpers shared by the scan, finish and top modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctip_pkg;

   // scan phases
   localparam logic [2:0] PH_SPACE      = 3'd0;
   localparam logic [2:0] PH_SIGNED     = 3'd1;
   localparam logic [2:0] PH_ZERO_AUTO  = 3'd2;
   localparam logic [2:0] PH_ZERO_HEX   = 3'd3;
   localparam logic [2:0] PH_ZERO_PLAIN = 3'd4;
   localparam logic [2:0] PH_PREFIX     = 3'd5;
   localparam logic [2:0] PH_DIGITS     = 3'd6;
   localparam logic [2:0] PH_TAIL       = 3'd7;

   // result status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_SPACE = 3'd1;
   localparam logic [2:0] ST_PLUS  = 3'd2;
   localparam logic [2:0] ST_MINUS = 3'd3;
   localparam logic [2:0] ST_RANGE = 3'd4;
   localparam logic [2:0] ST_NODIG = 3'd5;
   localparam logic [2:0] ST_TRAIL = 3'd6;
   localparam logic [2:0] ST_OTHER = 3'd7;

   // register indexes
   localparam logic [1:0] CSR_OPTION_MASK = 2'd0;
   localparam logic [1:0] CSR_NUMBER_BASE = 2'd1;
   localparam logic [1:0] CSR_RESULT_KIND = 2'd2;

   // option mask bits
   localparam int OPT_SPACE = 0;
   localparam int OPT_PLUS  = 1;
   localparam int OPT_MINUS = 2;
   localparam int OPT_SPEC  = 3;
   localparam int OPT_SAT   = 4;
   localparam int OPT_TRAIL = 5;

   // result kinds
   localparam logic [1:0] KIND_S32 = 2'd2;
   localparam logic [1:0] KIND_U32 = 2'd3;

   localparam logic [5:0] BASE_MAX   = 6'd36;
   localparam logic [5:0] BASE_DEC   = 6'd10;
   localparam logic [5:0] BASE_OCT   = 6'd8;
   localparam logic [5:0] BASE_HEX   = 6'd16;
   localparam logic [6:0] NOT_DIGIT  = 7'd99;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LX    = 8'h78;
   localparam logic [7:0] CHAR_UX    = 8'h58;

   typedef struct packed {
      logic [5:0] option_mask;
      logic [5:0] number_base;
      logic [1:0] result_kind;
   } cfg_type;

   typedef struct packed {
      logic [2:0] phase;
      logic       overflowed;
      logic       is_negative;
      logic       digit_seen;
      logic [2:0] early_error;
   } flags_type;

   function automatic logic [6:0] digit_of(input logic [7:0] c);
      logic [6:0] d;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = 7'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = 7'(c - 8'h61 + 8'd10);
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         d = 7'(c - 8'h41 + 8'd10);
      end else begin
         d = NOT_DIGIT;
      end
      return d;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
   endfunction

   function automatic logic base_bad(input cfg_type cfg);
      return (!cfg.option_mask[OPT_SPEC] && cfg.number_base == 6'd0) ||
             cfg.number_base == 6'd1 || cfg.number_base > BASE_MAX;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/ctip_scan.sv
// Scan state of the parser: phase, sign, accumulator and offsets.
// One byte per step; one multiply-add with overflow compare per digit. Uses ctip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctip_scan import ctip_pkg::*; #(
   parameter int WIDE_BITS = 64,
   parameter int MAX_LEN   = 4096,
   parameter int POS_W     = 13
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [7:0]           text_byte,
   input  wire cfg_type              cfg,
   output flags_type                 flags,
   output logic [WIDE_BITS-1:0]      accumulator,
   output logic [POS_W-1:0]          position,
   output logic [POS_W-1:0]          number_end
);

   localparam int PROD_W = WIDE_BITS + 6;
   localparam logic [WIDE_BITS-1:0] TOP = {1'b1, {(WIDE_BITS-1){1'b0}}};

   flags_type               flags_ff, flags_in;
   logic [WIDE_BITS-1:0]    acc_ff, acc_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [POS_W-1:0]        end_ff, end_in;
   logic [5:0]              base_ff, base_in;

   logic [5:0]              sel_base;
   logic [6:0]              digit;
   logic                    digit_ok;
   logic [WIDE_BITS-1:0]    lim;
   logic [PROD_W-1:0]       prod;
   logic                    ovf_now;
   logic                    do_digit;
   logic                    do_zero;
   logic [2:0]              zero_phase;
   logic                    is_x;

   // base that the digit unit works in this step
   always_comb begin
      unique case (flags_ff.phase) inside
         PH_SPACE, PH_SIGNED: sel_base = (cfg.number_base == 6'd0) ? BASE_DEC : cfg.number_base;
         PH_ZERO_AUTO:        sel_base = BASE_OCT;
         default:             sel_base = base_ff;
      endcase
   end

   assign digit    = digit_of(text_byte);
   assign digit_ok = (sel_base >= 6'd2) && (digit < {1'b0, sel_base});
   assign lim      = cfg.result_kind[0] ? {WIDE_BITS{1'b1}} :
                     (flags_ff.is_negative ? TOP : TOP - WIDE_BITS'(1));
   // acc > (lim - d) / base is the same as acc * base + d > lim
   assign prod     = PROD_W'(acc_ff) * PROD_W'(sel_base) + PROD_W'(digit);
   assign ovf_now  = prod > PROD_W'(lim);
   assign is_x     = (text_byte == CHAR_LX) || (text_byte == CHAR_UX);

   always_comb begin
      flags_in   = flags_ff;
      acc_in     = acc_ff;
      pos_in     = pos_ff;
      end_in     = end_ff;
      base_in    = base_ff;
      do_digit   = 1'b0;
      do_zero    = 1'b0;
      zero_phase = PH_DIGITS;

      if (flags_ff.early_error == ST_OK) begin
         unique case (flags_ff.phase) inside
            PH_SPACE, PH_SIGNED: begin
               if (flags_ff.phase == PH_SPACE && is_space(text_byte)) begin
                  if (!cfg.option_mask[OPT_SPACE]) begin
                     flags_in.early_error = ST_SPACE;
                     flags_in.phase       = PH_TAIL;
                  end
               end else if (flags_ff.phase == PH_SPACE && text_byte == CHAR_PLUS) begin
                  if (!cfg.option_mask[OPT_PLUS]) begin
                     flags_in.early_error = ST_PLUS;
                     flags_in.phase       = PH_TAIL;
                  end else begin
                     flags_in.is_negative = 1'b0;
                     flags_in.phase       = PH_SIGNED;
                  end
               end else if (flags_ff.phase == PH_SPACE && text_byte == CHAR_MINUS) begin
                  if (!cfg.option_mask[OPT_MINUS]) begin
                     flags_in.early_error = ST_MINUS;
                     flags_in.phase       = PH_TAIL;
                  end else begin
                     flags_in.is_negative = 1'b1;
                     flags_in.phase       = PH_SIGNED;
                  end
               end else if (base_bad(cfg)) begin
                  flags_in.early_error = ST_OTHER;
                  flags_in.phase       = PH_TAIL;
               end else if (cfg.number_base == 6'd0) begin
                  if (text_byte == CHAR_ZERO) begin
                     do_zero    = 1'b1;
                     zero_phase = PH_ZERO_AUTO;
                  end else begin
                     base_in  = BASE_DEC;
                     do_digit = 1'b1;
                  end
               end else begin
                  base_in = cfg.number_base;
                  if (cfg.number_base == BASE_HEX && text_byte == CHAR_ZERO) begin
                     do_zero    = 1'b1;
                     zero_phase = cfg.option_mask[OPT_SPEC] ? PH_ZERO_HEX : PH_ZERO_PLAIN;
                  end else begin
                     do_digit = 1'b1;
                  end
               end
            end
            PH_ZERO_AUTO: begin
               if (is_x) begin
                  base_in        = BASE_HEX;
                  flags_in.phase = PH_PREFIX;
               end else begin
                  base_in  = BASE_OCT;
                  do_digit = 1'b1;
               end
            end
            PH_ZERO_HEX: begin
               if (is_x) begin
                  flags_in.phase = PH_PREFIX;
               end else begin
                  do_digit = 1'b1;
               end
            end
            PH_ZERO_PLAIN: begin
               if (text_byte == CHAR_LX) begin
                  flags_in.phase = PH_TAIL;
               end else if (text_byte == CHAR_UX) begin
                  flags_in.phase = PH_PREFIX;
               end else begin
                  do_digit = 1'b1;
               end
            end
            PH_PREFIX: begin
               if (digit < 7'd16) begin
                  do_digit = 1'b1;
               end else begin
                  flags_in.phase = PH_TAIL;
               end
            end
            PH_DIGITS: do_digit = 1'b1;
            default:   ;
         endcase
      end

      if (do_zero) begin
         flags_in.digit_seen = 1'b1;
         acc_in              = '0;
         end_in              = pos_ff + POS_W'(1);
         flags_in.phase      = zero_phase;
      end

      if (do_digit) begin
         if (!digit_ok) begin
            flags_in.phase = PH_TAIL;
         end else begin
            if (!flags_ff.overflowed) begin
               if (ovf_now) begin
                  flags_in.overflowed = 1'b1;
               end else begin
                  acc_in = prod[WIDE_BITS-1:0];
               end
            end
            flags_in.digit_seen = 1'b1;
            end_in              = pos_ff + POS_W'(1);
            flags_in.phase      = PH_DIGITS;
         end
      end

      if (pos_ff < POS_W'(MAX_LEN)) begin
         pos_in = pos_ff + POS_W'(1);
      end

      // terminator: result is formed from the old state, then all clears
      if (text_byte == CHAR_NUL) begin
         flags_in = '{phase: PH_SPACE, overflowed: 1'b0, is_negative: 1'b0,
                      digit_seen: 1'b0, early_error: ST_OK};
         acc_in   = '0;
         pos_in   = '0;
         end_in   = '0;
         base_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '{phase: PH_SPACE, overflowed: 1'b0, is_negative: 1'b0,
                       digit_seen: 1'b0, early_error: ST_OK};
         acc_ff   <= '0;
         pos_ff   <= '0;
         end_ff   <= '0;
         base_ff  <= '0;
      end else if (step) begin
         flags_ff <= flags_in;
         acc_ff   <= acc_in;
         pos_ff   <= pos_in;
         end_ff   <= end_in;
         base_ff  <= base_in;
      end
   end

   assign flags       = flags_ff;
   assign accumulator = acc_ff;
   assign position    = pos_ff;
   assign number_end  = end_ff;

endmodule

`default_nettype wire

### hw/rtl/ctip_finish.sv
// Result forming for the parser: error order, saturation and 32-bit narrowing.
// Pure logic on the scan state at the terminator. Uses ctip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctip_finish import ctip_pkg::*; #(
   parameter int WIDE_BITS = 64,
   parameter int POS_W     = 13
) (
   input  wire cfg_type              cfg,
   input  wire flags_type            flags,
   input  wire logic [WIDE_BITS-1:0] accumulator,
   input  wire logic [POS_W-1:0]     position,
   input  wire logic [POS_W-1:0]     number_end,
   output logic [63:0]               parsed_value,
   output logic [2:0]                status,
   output logic [12:0]               end_offset
);

   localparam logic [63:0] TOP  = 64'd1 << (WIDE_BITS - 1);
   localparam logic [63:0] UMAX = TOP | (TOP - 64'd1);

   logic [63:0] acc64;
   logic [63:0] neg_acc;
   logic [63:0] biased;

   assign acc64   = 64'(accumulator);
   assign neg_acc = 64'd0 - acc64;

   always_comb begin
      logic [2:0]  st;
      logic [63:0] v;
      logic        sat;
      st  = flags.early_error;
      sat = cfg.option_mask[OPT_SAT];
      v   = '0;

      if (st == ST_OK && (flags.phase == PH_SPACE || flags.phase == PH_SIGNED) &&
          base_bad(cfg)) begin
         st = ST_OTHER;
      end
      if (st == ST_OK && flags.overflowed && !sat) begin
         st = ST_RANGE;
      end
      if (st == ST_OK && !flags.digit_seen) begin
         st = ST_NODIG;
      end

      if (st == ST_OK) begin
         if (cfg.result_kind[0]) begin
            if (flags.overflowed) begin
               v = UMAX;
            end else begin
               v = flags.is_negative ? (neg_acc & UMAX) : acc64;
            end
            // negative unsigned: range, or zero when saturating
            if (flags.is_negative && v != 64'd0) begin
               if (!sat) begin
                  st = ST_RANGE;
               end
               v = '0;
            end
         end else begin
            if (flags.overflowed) begin
               v = flags.is_negative ? (64'd0 - TOP) : (TOP - 64'd1);
            end else begin
               v = flags.is_negative ? neg_acc : acc64;
            end
         end
      end

      if (st == ST_OK && number_end != position && !cfg.option_mask[OPT_TRAIL]) begin
         st = ST_TRAIL;
      end

      biased = v + 64'h0000_0000_8000_0000;
      if (st == ST_OK && cfg.result_kind == KIND_S32) begin
         if (biased[63:32] != 32'd0) begin
            if (!sat) begin
               st = ST_RANGE;
            end else begin
               v = v[63] ? 64'hFFFF_FFFF_8000_0000 : 64'h0000_0000_7FFF_FFFF;
            end
         end
      end else if (st == ST_OK && cfg.result_kind == KIND_U32) begin
         if (v[63:32] != 32'd0) begin
            if (!sat) begin
               st = ST_RANGE;
            end else begin
               v = 64'h0000_0000_FFFF_FFFF;
            end
         end
      end

      parsed_value = (st == ST_OK) ? v : 64'd0;
      status       = st;
      end_offset   = (st == ST_OK) ? number_end[12:0] : 13'd0;
   end

endmodule

`default_nettype wire

### hw/rtl/checked_integer_text_parser_unit.sv
// Checked integer text parser: converts a byte string to a 32- or 64-bit integer.
// A request carries one byte of text; a zero byte ends the string and makes one
// response with the value, a status code and the offset just past the last digit.
// Every other byte produces no response. Options, radix and result kind must be
// set through the csr_ write port while no string is in flight; this is unchecked.
// Timing: a request is registered in the input register on acceptance and scanned
// when it leaves that register; a terminator then writes its response into the
// response register, where rsp_valid shows it until it is taken.
// One request is taken every cycle while req_stall is low; the digit path is one
// 64x6 multiply-add and compare per byte, which sets the clock rate.
// Reset (synchronous) clears the scan state and loads option_mask 0, radix 10,
// result kind signed 64. A stalled response holds its payload; further text bytes
// still flow until a second terminator meets the full response register, at which
// point req_stall rises until the response is taken.
// Uses ctip_pkg, ctip_scan, ctip_finish.
`timescale 1ns / 1ps
`default_nettype none

module checked_integer_text_parser_unit import ctip_pkg::*; #(
   parameter int MAX_LEN   = 4096,
   parameter int WIDE_BITS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_text_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_parsed_value,
   output logic [2:0]       rsp_status,
   output logic [12:0]      rsp_end_offset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [5:0]  csr_write_data
);

   localparam int POS_BITS = $clog2(MAX_LEN + 2);
   localparam int POS_W    = (POS_BITS > 13) ? POS_BITS : 13;

   cfg_type               cfg_ff, cfg_in;

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_is_term;
   logic                  out_free;
   logic                  advance;

   logic                  out_valid_ff, out_valid_in;
   logic [63:0]           out_value_ff;
   logic [2:0]            out_status_ff;
   logic [12:0]           out_end_ff;

   flags_type             flags;
   logic [WIDE_BITS-1:0]  accumulator;
   logic [POS_W-1:0]      position;
   logic [POS_W-1:0]      number_end;
   logic [63:0]           fin_value;
   logic [2:0]            fin_status;
   logic [12:0]           fin_end;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OPTION_MASK: cfg_in.option_mask = csr_write_data;
            CSR_NUMBER_BASE: cfg_in.number_base = csr_write_data;
            CSR_RESULT_KIND: cfg_in.result_kind = csr_write_data[1:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{option_mask: 6'd0, number_base: BASE_DEC, result_kind: 2'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register; only a terminator can be held back by the response side
   assign in_is_term   = (in_byte_ff == CHAR_NUL);
   assign out_free     = !out_valid_ff || !rsp_stall;
   assign advance      = in_valid_ff && (!in_is_term || out_free);
   assign req_stall    = in_valid_ff && !advance;
   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_text_byte;
      end
   end

   ctip_scan #(
      .WIDE_BITS (WIDE_BITS),
      .MAX_LEN   (MAX_LEN),
      .POS_W     (POS_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .text_byte   (in_byte_ff),
      .cfg         (cfg_ff),
      .flags       (flags),
      .accumulator (accumulator),
      .position    (position),
      .number_end  (number_end)
   );

   ctip_finish #(
      .WIDE_BITS (WIDE_BITS),
      .POS_W     (POS_W)
   ) u_finish (
      .cfg          (cfg_ff),
      .flags        (flags),
      .accumulator  (accumulator),
      .position     (position),
      .number_end   (number_end),
      .parsed_value (fin_value),
      .status       (fin_status),
      .end_offset   (fin_end)
   );

   // response register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && in_is_term) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_is_term) begin
         out_value_ff  <= fin_value;
         out_status_ff <= fin_status;
         out_end_ff    <= fin_end;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_parsed_value = out_value_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_end_offset   = out_end_ff;

endmodule

`default_nettype wire
